// ----- src/cps_pkg.sv -----
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants of the coordinate path stack
// Operation and status codes, entry layout, cell control group.
// ----------------------------------------------------------------------------
package cps_pkg;

	localparam int MAX_DEPTH_DEF = 64;
	localparam int COORD_W       = 16;
	localparam int CAP_W         = 7;
	localparam int LEN_W         = 7;
	localparam int OP_W          = 3;
	localparam int ST_W          = 2;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = 3;

	localparam logic [COORD_W-1:0] COORD_NONE = 16'hFFFF;
	localparam logic [CAP_W-1:0]   CAP_RESET  = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_SEARCH = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// register index of the capacity register
	localparam logic REG_CAPACITY = 1'b0;

	// one stored coordinate with its adjacency to the entry below
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               adj;
	} entry_t;

	// shift controls shared by every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} cell_ctl_t;

endpackage

// ----- src/cps_cell.sv -----
// ----------------------------------------------------------------------------
// cps_cell: one slot of the shift-register stack
// Holds one entry, shifts down on push and up on pop, compares against key.
// ----------------------------------------------------------------------------
module cps_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cps_pkg::cell_ctl_t             ctl,
	input  cps_pkg::entry_t                up_ent,
	input  logic                           up_vld,
	input  cps_pkg::entry_t                dn_ent,
	input  logic                           dn_vld,
	input  logic [cps_pkg::COORD_W-1:0]    key_row,
	input  logic [cps_pkg::COORD_W-1:0]    key_col,
	output cps_pkg::entry_t                ent,
	output logic                           vld,
	output logic                           match
);

	cps_pkg::entry_t ent_q;
	logic            vld_q;

	// occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clear) begin
			vld_q <= 1'b0;
		end else if (ctl.push) begin
			vld_q <= up_vld;
		end else if (ctl.pop) begin
			vld_q <= dn_vld;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ent_q <= up_ent;
		end else if (ctl.pop) begin
			ent_q <= dn_ent;
		end
	end

	// local search compare
	assign match = vld_q && (ent_q.row == key_row) && (ent_q.col == key_col);
	assign ent   = ent_q;
	assign vld   = vld_q;

endmodule

// ----- src/cps_chain.sv -----
// ----------------------------------------------------------------------------
// cps_chain: row of stack cells
// Cell 0 is the top of the stack; new entries enter there and shift down.
// ----------------------------------------------------------------------------
module cps_chain #(
	parameter int DEPTH = cps_pkg::MAX_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cps_pkg::cell_ctl_t             ctl,
	input  cps_pkg::entry_t                new_ent,
	input  logic [cps_pkg::COORD_W-1:0]    key_row,
	input  logic [cps_pkg::COORD_W-1:0]    key_col,
	output cps_pkg::entry_t                top_ent,
	output logic                           found
);

	cps_pkg::entry_t ent   [DEPTH];
	logic            vld   [DEPTH];
	logic [DEPTH-1:0] match;

	// neighbor links
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cps_pkg::entry_t up_ent;
		logic            up_vld;
		cps_pkg::entry_t dn_ent;
		logic            dn_vld;

		if (i == 0) begin : g_top
			assign up_ent = new_ent;
			assign up_vld = 1'b1;
		end else begin : g_mid
			assign up_ent = ent[i-1];
			assign up_vld = vld[i-1];
		end

		if (i == DEPTH-1) begin : g_bot
			assign dn_ent = new_ent;
			assign dn_vld = 1'b0;
		end else begin : g_inner
			assign dn_ent = ent[i+1];
			assign dn_vld = vld[i+1];
		end

		cps_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.up_ent  (up_ent),
			.up_vld  (up_vld),
			.dn_ent  (dn_ent),
			.dn_vld  (dn_vld),
			.key_row (key_row),
			.key_col (key_col),
			.ent     (ent[i]),
			.vld     (vld[i]),
			.match   (match[i])
		);
	end

	assign top_ent = ent[0];
	assign found   = |match;

endmodule

// ----- src/coordinate_path_stack_top.sv -----
// ----------------------------------------------------------------------------
// coordinate_path_stack_top: bounded stack of grid coordinates
// Push, pop, peek, search and clear on a shift-register stack; keeps the
// length and a count of non-adjacent steps for the contiguity flag.
//
//   channel   handshake              payload
//   command   start / busy           operation, row, col
//   result    done (one cycle)       out_row, out_col, found, contiguous,
//                                    length, status
//   config    APB psel/penable       paddr, pwdata, prdata (capacity)
//
// Each item is accepted when start is high: its result is registered and is on the result ports
// in the cycle after the start edge, and a new item may be given in that same cycle.
// busy stays low; each cell compares combinationally and shifts on the clock.
// Reset empties the stack and sets capacity to 64; no clearing pass.
// The result receiver cannot stall, so done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module coordinate_path_stack_top #(
	parameter int MAX_DEPTH = cps_pkg::MAX_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command
	input  logic                           start,
	output logic                           busy,
	input  logic [cps_pkg::OP_W-1:0]       operation,
	input  logic [cps_pkg::COORD_W-1:0]    row,
	input  logic [cps_pkg::COORD_W-1:0]    col,
	// result
	output logic                           done,
	output logic [cps_pkg::COORD_W-1:0]    out_row,
	output logic [cps_pkg::COORD_W-1:0]    out_col,
	output logic                           found,
	output logic                           contiguous,
	output logic [cps_pkg::LEN_W-1:0]      length,
	output logic [cps_pkg::ST_W-1:0]       status,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cps_pkg::ADDR_W-1:0]     paddr,
	input  logic [cps_pkg::DATA_W-1:0]     pwdata,
	output logic [cps_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);

	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int EXT_W = CNT_W + cps_pkg::CAP_W;

	logic [cps_pkg::CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]            count_q, count_nxt;
	logic [CNT_W-1:0]            brk_q, brk_nxt;

	logic                        done_q;
	logic [cps_pkg::COORD_W-1:0] out_row_q, out_col_q, orow_c, ocol_c;
	logic                        found_q, found_c;
	logic                        contig_q;
	logic [cps_pkg::LEN_W-1:0]   length_q;
	cps_pkg::status_t            status_q, status_c;

	cps_pkg::cell_ctl_t          ctl;
	cps_pkg::entry_t             new_ent, top_ent;
	logic                        match_any;

	logic                        acc, is_empty, is_full, adj_new;
	logic [cps_pkg::COORD_W:0]   rdiff, cdiff;
	logic                        r_eq, c_eq, r_one, c_one;
	logic [EXT_W-1:0]            count_ext, cap_ext;
	cps_pkg::op_t                op;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign acc    = start && !busy;
	assign op     = cps_pkg::op_t'(operation);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cps_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == cps_pkg::REG_CAPACITY)) begin
			cap_q <= pwdata[cps_pkg::CAP_W-1:0];
		end
	end

	// register read back
	always_comb begin
		prdata = '0;
		if (paddr[2] == cps_pkg::REG_CAPACITY) begin
			prdata[cps_pkg::CAP_W-1:0] = cap_q;
		end
	end

	// fill level checks
	assign count_ext = {{cps_pkg::CAP_W{1'b0}}, count_q};
	assign cap_ext   = {{CNT_W{1'b0}}, cap_q};
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_ext >= cap_ext) || (count_q >= CNT_W'(MAX_DEPTH));

	// unit step test against the current top
	assign rdiff   = {1'b0, row} - {1'b0, top_ent.row};
	assign cdiff   = {1'b0, col} - {1'b0, top_ent.col};
	assign r_eq    = (rdiff == '0);
	assign c_eq    = (cdiff == '0);
	assign r_one   = (rdiff == (cps_pkg::COORD_W+1)'(1)) || (rdiff == '1);
	assign c_one   = (cdiff == (cps_pkg::COORD_W+1)'(1)) || (cdiff == '1);
	assign adj_new = is_empty || (r_eq && c_one) || (c_eq && r_one);

	assign new_ent = '{row: row, col: col, adj: adj_new};

	// operation decode and next state
	always_comb begin
		ctl       = '0;
		count_nxt = count_q;
		brk_nxt   = brk_q;
		orow_c    = '0;
		ocol_c    = '0;
		found_c   = 1'b0;
		status_c  = cps_pkg::ST_OK;
		case (op)
			cps_pkg::OP_PUSH: begin
				if (is_full) begin
					status_c = cps_pkg::ST_FULL;
				end else begin
					ctl.push  = acc;
					count_nxt = count_q + CNT_W'(1);
					if (!adj_new) begin
						brk_nxt = brk_q + CNT_W'(1);
					end
				end
			end
			cps_pkg::OP_POP, cps_pkg::OP_PEEK: begin
				if (is_empty) begin
					orow_c   = cps_pkg::COORD_NONE;
					ocol_c   = cps_pkg::COORD_NONE;
					status_c = cps_pkg::ST_EMPTY;
				end else begin
					orow_c = top_ent.row;
					ocol_c = top_ent.col;
					if (op == cps_pkg::OP_POP) begin
						ctl.pop   = acc;
						count_nxt = count_q - CNT_W'(1);
						if ((count_q > CNT_W'(1)) && !top_ent.adj && (brk_q != '0)) begin
							brk_nxt = brk_q - CNT_W'(1);
						end
					end
				end
			end
			cps_pkg::OP_SEARCH: begin
				if (is_empty) begin
					status_c = cps_pkg::ST_EMPTY;
				end else if ((row == cps_pkg::COORD_NONE) || (col == cps_pkg::COORD_NONE)) begin
					status_c = cps_pkg::ST_INVALID;
				end else begin
					found_c = match_any;
				end
			end
			cps_pkg::OP_CLEAR: begin
				ctl.clear = acc;
				count_nxt = '0;
				brk_nxt   = '0;
			end
			default: begin
			end
		endcase
	end

	// stack cells
	cps_chain #(
		.DEPTH (MAX_DEPTH)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.new_ent (new_ent),
		.key_row (row),
		.key_col (col),
		.top_ent (top_ent),
		.found   (match_any)
	);

	// length and break count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			brk_q   <= '0;
		end else if (acc) begin
			count_q <= count_nxt;
			brk_q   <= brk_nxt;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= acc;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			out_row_q <= orow_c;
			out_col_q <= ocol_c;
			found_q   <= found_c;
			contig_q  <= (brk_nxt == '0);
			length_q  <= cps_pkg::LEN_W'({{cps_pkg::LEN_W{1'b0}}, count_nxt});
			status_q  <= status_c;
		end
	end

	assign done       = done_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign found      = found_q;
	assign contiguous = contig_q;
	assign length     = length_q;
	assign status     = status_q;

endmodule
